/* hdl/lgpg_pkg.sv */
// Shared types, codes and color tables of the LED grid pattern generator.
package lgpg_pkg;

    localparam int unsigned COL_W      = 5;
    localparam int unsigned ROW_W      = 4;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 5;

    localparam int unsigned RING_LEN   = 80;
    localparam int unsigned STRIPE_LEN = 24;

    localparam logic [COL_W-1:0] CENTER_COL_RST = 5'd8;
    localparam logic [ROW_W-1:0] CENTER_ROW_RST = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_COL = 1'b0,
        CFG_CENTER_ROW = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_GRADIENT = 2'd0,
        MODE_RINGS    = 2'd1,
        MODE_STRIPES  = 2'd2,
        MODE_RAINBOW  = 2'd3
    } mode_t;

    // Load enables of the pipeline registers behind the input stage
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } adv_t;

    // Time phases and cell data after the reduction stage
    typedef struct packed {
        mode_t            mode;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       wheel_step;
        logic [6:0]       ring_step;
        logic [4:0]       stripe_step;
        logic [7:0]       base;
    } phase_t;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    localparam rgb_t RING_PAL [RING_LEN] = '{
        '{8'd1, 8'd121, 8'd192},   '{8'd10, 8'd126, 8'd192},  '{8'd19, 8'd131, 8'd192},
        '{8'd28, 8'd136, 8'd200},  '{8'd37, 8'd141, 8'd203},  '{8'd47, 8'd146, 8'd205},
        '{8'd56, 8'd151, 8'd208},  '{8'd65, 8'd157, 8'd211},  '{8'd74, 8'd162, 8'd214},
        '{8'd83, 8'd167, 8'd216},  '{8'd93, 8'd172, 8'd219},  '{8'd102, 8'd177, 8'd222},
        '{8'd111, 8'd182, 8'd225}, '{8'd120, 8'd187, 8'd227}, '{8'd129, 8'd193, 8'd230},
        '{8'd139, 8'd198, 8'd233}, '{8'd148, 8'd203, 8'd236}, '{8'd157, 8'd208, 8'd238},
        '{8'd166, 8'd213, 8'd241}, '{8'd175, 8'd218, 8'd244}, '{8'd185, 8'd224, 8'd247},
        '{8'd175, 8'd215, 8'd247}, '{8'd166, 8'd207, 8'd247}, '{8'd157, 8'd198, 8'd247},
        '{8'd148, 8'd190, 8'd247}, '{8'd138, 8'd182, 8'd247}, '{8'd129, 8'd173, 8'd247},
        '{8'd120, 8'd165, 8'd248}, '{8'd111, 8'd157, 8'd248}, '{8'd101, 8'd148, 8'd248},
        '{8'd92, 8'd140, 8'd248},  '{8'd83, 8'd132, 8'd248},  '{8'd74, 8'd123, 8'd248},
        '{8'd64, 8'd115, 8'd248},  '{8'd55, 8'd107, 8'd249},  '{8'd46, 8'd98, 8'd249},
        '{8'd37, 8'd90, 8'd249},   '{8'd27, 8'd82, 8'd249},   '{8'd18, 8'd73, 8'd249},
        '{8'd9, 8'd65, 8'd249},    '{8'd0, 8'd57, 8'd250},    '{8'd0, 8'd57, 8'd242},
        '{8'd0, 8'd57, 8'd234},    '{8'd0, 8'd58, 8'd226},    '{8'd0, 8'd58, 8'd218},
        '{8'd0, 8'd59, 8'd211},    '{8'd0, 8'd59, 8'd203},    '{8'd0, 8'd59, 8'd195},
        '{8'd0, 8'd60, 8'd187},    '{8'd0, 8'd60, 8'd179},    '{8'd0, 8'd61, 8'd172},
        '{8'd0, 8'd61, 8'd164},    '{8'd0, 8'd61, 8'd156},    '{8'd0, 8'd62, 8'd148},
        '{8'd0, 8'd62, 8'd140},    '{8'd0, 8'd63, 8'd133},    '{8'd0, 8'd63, 8'd125},
        '{8'd0, 8'd63, 8'd117},    '{8'd0, 8'd64, 8'd109},    '{8'd0, 8'd64, 8'd101},
        '{8'd0, 8'd65, 8'd94},     '{8'd0, 8'd67, 8'd98},     '{8'd0, 8'd70, 8'd103},
        '{8'd0, 8'd73, 8'd108},    '{8'd0, 8'd76, 8'd113},    '{8'd0, 8'd79, 8'd118},
        '{8'd0, 8'd81, 8'd123},    '{8'd0, 8'd84, 8'd128},    '{8'd0, 8'd87, 8'd133},
        '{8'd0, 8'd90, 8'd138},    '{8'd0, 8'd93, 8'd143},    '{8'd0, 8'd95, 8'd147},
        '{8'd0, 8'd98, 8'd152},    '{8'd0, 8'd101, 8'd157},   '{8'd0, 8'd104, 8'd162},
        '{8'd0, 8'd107, 8'd167},   '{8'd0, 8'd109, 8'd172},   '{8'd0, 8'd112, 8'd177},
        '{8'd0, 8'd115, 8'd182},   '{8'd0, 8'd118, 8'd187}
    };

    localparam rgb_t STRIPE_PAL [STRIPE_LEN] = '{
        '{8'd1, 8'd121, 8'd192},   '{8'd31, 8'd138, 8'd201},  '{8'd62, 8'd155, 8'd210},
        '{8'd93, 8'd172, 8'd219},  '{8'd123, 8'd189, 8'd228}, '{8'd152, 8'd206, 8'd237},
        '{8'd185, 8'd224, 8'd247}, '{8'd152, 8'd196, 8'd247}, '{8'd123, 8'd168, 8'd248},
        '{8'd92, 8'd140, 8'd248},  '{8'd61, 8'd112, 8'd249},  '{8'd30, 8'd84, 8'd249},
        '{8'd0, 8'd57, 8'd250},    '{8'd0, 8'd58, 8'd224},    '{8'd0, 8'd59, 8'd198},
        '{8'd0, 8'd61, 8'd172},    '{8'd0, 8'd62, 8'd146},    '{8'd0, 8'd62, 8'd120},
        '{8'd0, 8'd65, 8'd94},     '{8'd0, 8'd74, 8'd110},    '{8'd0, 8'd83, 8'd126},
        '{8'd0, 8'd93, 8'd143},    '{8'd0, 8'd102, 8'd159},   '{8'd0, 8'd111, 8'd175}
    };

endpackage

/* hdl/led_grid_pattern_generator.sv */
// LED grid pattern generator top level: input stage, pipeline control, config registers.
// An accepted cell passes through 5 register stages before its color shows.
// Throughput: one cell per clock while not stalled; a full stage holds while the stage ahead is full and stalled.
// The time divides are constant reciprocal multiplies, one stage ahead of the modulo folds.
// Reset: all stage valids clear, center_col returns to 8 and center_row to 4.
// Config port is always ready.
module led_grid_pattern_generator
    import lgpg_pkg::*;
#(
    parameter int GRID_COLS = 17,
    parameter int GRID_ROWS = 9
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cell_valid,
    output logic                  cell_stall,
    input  logic [1:0]            mode,
    input  logic [COL_W-1:0]      cell_col,
    input  logic [ROW_W-1:0]      cell_row,
    input  logic [TIME_W-1:0]     time_ms,
    output logic                  color_valid,
    input  logic                  color_stall,
    output logic [CHAN_W-1:0]     red,
    output logic [CHAN_W-1:0]     green,
    output logic [CHAN_W-1:0]     blue,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [4:0]        valid_reg;
    logic [5:0]        ready;
    adv_t              adv;

    mode_t             mode_s1_reg;
    logic [COL_W-1:0]  col_s1_reg;
    logic [ROW_W-1:0]  row_s1_reg;
    logic [TIME_W-1:0] time_s1_reg;

    logic [COL_W-1:0]  center_col_reg;
    logic [ROW_W-1:0]  center_row_reg;

    phase_t            phase;

    always_comb
    begin
        ready[5] = !color_stall;
        for (int i = 4; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    assign cell_stall  = !ready[0];
    assign color_valid = valid_reg[4];
    assign cfg_ready   = 1'b1;

    assign adv.s2 = ready[1];
    assign adv.s3 = ready[2];
    assign adv.s4 = ready[3];
    assign adv.s5 = ready[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= cell_valid;
            end
            for (int i = 1; i < 5; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            mode_s1_reg <= mode_t'(mode);
            col_s1_reg  <= cell_col;
            row_s1_reg  <= cell_row;
            time_s1_reg <= time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg <= CENTER_COL_RST;
            center_row_reg <= CENTER_ROW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_CENTER_COL:
                begin
                    center_col_reg <= cfg_data[COL_W-1:0];
                end
                CFG_CENTER_ROW:
                begin
                    center_row_reg <= cfg_data[ROW_W-1:0];
                end
                default:
                begin
                    center_col_reg <= center_col_reg;
                end
            endcase
        end
    end

    lgpg_phase #(
        .GRID_COLS (GRID_COLS)
    ) u_phase (
        .clk     (clk),
        .adv     (adv),
        .mode    (mode_s1_reg),
        .col     (col_s1_reg),
        .row     (row_s1_reg),
        .time_ms (time_s1_reg),
        .phase   (phase)
    );

    lgpg_shade #(
        .GRID_ROWS (GRID_ROWS)
    ) u_shade (
        .clk        (clk),
        .adv        (adv),
        .phase      (phase),
        .center_col (center_col_reg),
        .center_row (center_row_reg),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

/* hdl/lgpg_phase.sv */
// Time phase stages: reciprocal divides of the time, then reduction to pattern steps.
module lgpg_phase
    import lgpg_pkg::*;
#(
    parameter int GRID_COLS = 17
)
(
    input  logic              clk,
    input  adv_t              adv,
    input  mode_t             mode,
    input  logic [COL_W-1:0]  col,
    input  logic [ROW_W-1:0]  row,
    input  logic [TIME_W-1:0] time_ms,
    output phase_t            phase
);

    // floor(x/d) = (x * m) >> k, exact over the shifted time range
    localparam logic [30:0] RECIP_5  = 31'd1717986919;
    localparam logic [29:0] RECIP_15 = 30'd572662307;
    localparam logic [30:0] RECIP_25 = 31'd1374389535;

    // x mod 255 by folding bytes
    function automatic logic [7:0] mod255_q(input logic [27:0] q);
        logic [9:0] a;
        logic [8:0] b;
        a = 10'(q[27:24]) + 10'(q[23:16]) + 10'(q[15:8]) + 10'(q[7:0]);
        b = 9'(a[9:8]) + 9'(a[7:0]);
        return (b >= 9'd255) ? 8'(b - 9'd255) : b[7:0];
    endfunction

    // x mod 80 = 16 * ((x >> 4) mod 5) + x[3:0]; nibbles fold mod 5
    function automatic logic [6:0] mod80_q(input logic [25:0] q);
        logic [6:0] s;
        logic [4:0] f;
        logic [4:0] m;
        s = 7'(q[25:24]) + 7'(q[23:20]) + 7'(q[19:16]) + 7'(q[15:12])
          + 7'(q[11:8]) + 7'(q[7:4]);
        f = 5'(s[6:4]) + 5'(s[3:0]);
        if (f >= 5'd20)
        begin
            m = f - 5'd20;
        end
        else if (f >= 5'd15)
        begin
            m = f - 5'd15;
        end
        else if (f >= 5'd10)
        begin
            m = f - 5'd10;
        end
        else if (f >= 5'd5)
        begin
            m = f - 5'd5;
        end
        else
        begin
            m = f;
        end
        return {m[2:0], q[3:0]};
    endfunction

    // x mod 24 = 8 * ((x >> 3) mod 3) + x[2:0]; bit pairs fold mod 3
    function automatic logic [4:0] mod24_q(input logic [25:0] q);
        logic [5:0] s;
        logic [3:0] f;
        logic [3:0] m;
        s = 6'(q[25]);
        for (int i = 0; i < 11; i++)
        begin
            s = s + 6'(q[3 + 2*i +: 2]);
        end
        f = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
        if (f >= 4'd6)
        begin
            m = f - 4'd6;
        end
        else if (f >= 4'd3)
        begin
            m = f - 4'd3;
        end
        else
        begin
            m = f;
        end
        return {m[1:0], q[2:0]};
    endfunction

    logic [60:0] prod20;
    logic [58:0] prod120;
    logic [60:0] prod100;

    mode_t            mode_s2_reg;
    logic [COL_W-1:0] col_s2_reg;
    logic [ROW_W-1:0] row_s2_reg;
    logic [27:0]      q20_reg;
    logic [25:0]      q120_reg;
    logic [25:0]      q100_reg;

    logic [11:0]      lin;
    logic [8:0]       lin_fold;
    phase_t           phase_next;
    phase_t           phase_reg;

    assign prod20  = 61'(time_ms[31:2]) * 61'(RECIP_5);
    assign prod120 = 59'(time_ms[31:3]) * 59'(RECIP_15);
    assign prod100 = 61'(time_ms[31:2]) * 61'(RECIP_25);

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            mode_s2_reg <= mode;
            col_s2_reg  <= col;
            row_s2_reg  <= row;
            q20_reg     <= prod20[60:33];
            q120_reg    <= prod120[58:33];
            q100_reg    <= prod100[60:35];
        end
    end

    always_comb
    begin
        lin      = 12'(row_s2_reg) * 12'(GRID_COLS) + 12'(col_s2_reg);
        lin_fold = 9'(lin[11:8]) + 9'(lin[7:0]);

        phase_next.mode        = mode_s2_reg;
        phase_next.col         = col_s2_reg;
        phase_next.row         = row_s2_reg;
        phase_next.wheel_step  = mod255_q(q20_reg);
        phase_next.ring_step   = mod80_q(q120_reg);
        phase_next.stripe_step = mod24_q(q100_reg);
        phase_next.base        = (lin_fold >= 9'd255) ? 8'(lin_fold - 9'd255) : lin_fold[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

/* hdl/lgpg_shade.sv */
// Color stages: wheel position and palette indexes, then the per-mode color.
module lgpg_shade
    import lgpg_pkg::*;
#(
    parameter int GRID_ROWS = 9
)
(
    input  logic              clk,
    input  adv_t              adv,
    input  phase_t            phase,
    input  logic [COL_W-1:0]  center_col,
    input  logic [ROW_W-1:0]  center_row,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue
);

    localparam int ROWS_MOD = GRID_ROWS % 24;

    logic [8:0]       pos_sum;
    logic [COL_W-1:0] dist_col;
    logic [ROW_W-1:0] dist_row;
    logic [5:0]       dist_sum;
    logic [6:0]       ring_sum;
    logic [6:0]       stripe_sum;

    mode_t       mode_s4_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  pos_next;
    logic [6:0]  ring_idx_reg;
    logic [6:0]  ring_idx_next;
    logic [4:0]  stripe_idx_reg;
    logic [4:0]  stripe_idx_next;

    logic [7:0]  fold;
    logic [7:0]  wdist;
    logic [7:0]  wrel;
    logic [9:0]  wrel3;
    rgb_t        color_next;
    rgb_t        color_reg;

    always_comb
    begin
        pos_sum  = 9'(phase.base) + 9'(phase.wheel_step);
        pos_next = (pos_sum >= 9'd255) ? 8'(pos_sum - 9'd255) : pos_sum[7:0];

        dist_col = (phase.col >= center_col) ? phase.col - center_col : center_col - phase.col;
        dist_row = (phase.row >= center_row) ? phase.row - center_row : center_row - phase.row;
        dist_sum = 6'(dist_col) + 6'(dist_row);
        ring_sum = 7'(dist_sum) + 7'(RING_LEN) - phase.ring_step;
        ring_idx_next = (ring_sum >= 7'(RING_LEN)) ? ring_sum - 7'(RING_LEN) : ring_sum;

        stripe_sum = 7'(ROWS_MOD) + 7'(STRIPE_LEN) - 7'(phase.row) + 7'(phase.stripe_step);
        if (stripe_sum >= 7'(2 * STRIPE_LEN))
        begin
            stripe_idx_next = 5'(stripe_sum - 7'(2 * STRIPE_LEN));
        end
        else if (stripe_sum >= 7'(STRIPE_LEN))
        begin
            stripe_idx_next = 5'(stripe_sum - 7'(STRIPE_LEN));
        end
        else
        begin
            stripe_idx_next = 5'(stripe_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            mode_s4_reg    <= phase.mode;
            pos_reg        <= pos_next;
            ring_idx_reg   <= ring_idx_next;
            stripe_idx_reg <= stripe_idx_next;
        end
    end

    always_comb
    begin
        fold  = (pos_reg > 8'd127) ? 8'd255 - pos_reg : pos_reg;
        wdist = 8'd255 - pos_reg;
        if (wdist < 8'd85)
        begin
            wrel = wdist;
        end
        else if (wdist < 8'd170)
        begin
            wrel = wdist - 8'd85;
        end
        else
        begin
            wrel = wdist - 8'd170;
        end
        wrel3 = 10'(wrel) * 10'd3;

        color_next = '0;
        case (mode_s4_reg)
            MODE_GRADIENT:
            begin
                color_next.g = {fold[6:0], 1'b0};
                color_next.b = 8'd255 - {fold[6:0], 1'b0};
            end
            MODE_RINGS:
            begin
                color_next = RING_PAL[ring_idx_reg];
            end
            MODE_STRIPES:
            begin
                color_next = STRIPE_PAL[stripe_idx_reg];
            end
            MODE_RAINBOW:
            begin
                if (wdist < 8'd85)
                begin
                    color_next.r = 8'd255 - wrel3[7:0];
                    color_next.b = wrel3[7:0];
                end
                else if (wdist < 8'd170)
                begin
                    color_next.g = wrel3[7:0];
                    color_next.b = 8'd255 - wrel3[7:0];
                end
                else
                begin
                    color_next.r = wrel3[7:0];
                    color_next.g = 8'd255 - wrel3[7:0];
                end
            end
            default:
            begin
                color_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv.s5)
        begin
            color_reg <= color_next;
        end
    end

    assign red   = color_reg.r;
    assign green = color_reg.g;
    assign blue  = color_reg.b;

endmodule

/* hdl/lgpg_checker.sv */
// Port-level checks of the LED grid pattern generator, bound to the top level.
module lgpg_checker
    import lgpg_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cell_valid,
    input logic                  cell_stall,
    input logic                  color_valid,
    input logic                  color_stall,
    input logic [CHAN_W-1:0]     red,
    input logic [CHAN_W-1:0]     green,
    input logic [CHAN_W-1:0]     blue
);

    // input only backs up when the whole pipe is full behind a stalled result
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> color_valid && color_stall)
        else $error("cell_stall raised without a stalled result");

    // an accepted cell reaches, or is queued behind, the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_stall |-> ##5 color_valid)
        else $error("no result 5 cycles after an accepted transaction");

    // a new result run starts only from a cell that the input stage accepted
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(color_valid) |-> $past(cell_valid && !cell_stall, 5))
        else $error("result appeared without an accepted transaction");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_stall |=>
            color_valid && $stable(red) && $stable(green) && $stable(blue))
        else $error("stalled result changed");

endmodule

bind led_grid_pattern_generator lgpg_checker u_lgpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cell_valid  (cell_valid),
    .cell_stall  (cell_stall),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .red         (red),
    .green       (green),
    .blue        (blue)
);

/* tb/led_grid_pattern_generator_checker.sv */
`timescale 1ns / 1ps
// Color checker: predicts each cell color and matches it against the color channel.
module led_grid_pattern_generator_checker
    import lgpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cell_valid,
    input  logic                  cell_stall,
    input  logic [1:0]            mode,
    input  logic [COL_W-1:0]      cell_col,
    input  logic [ROW_W-1:0]      cell_row,
    input  logic [TIME_W-1:0]     time_ms,
    input  logic                  color_valid,
    input  logic                  color_stall,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    localparam int unsigned GRID_COLS = 17;
    localparam int unsigned GRID_ROWS = 9;

    localparam logic [23:0] RING_COLORS [80] = '{
        {8'd1, 8'd121, 8'd192},   {8'd10, 8'd126, 8'd192},  {8'd19, 8'd131, 8'd192},
        {8'd28, 8'd136, 8'd200},  {8'd37, 8'd141, 8'd203},  {8'd47, 8'd146, 8'd205},
        {8'd56, 8'd151, 8'd208},  {8'd65, 8'd157, 8'd211},  {8'd74, 8'd162, 8'd214},
        {8'd83, 8'd167, 8'd216},  {8'd93, 8'd172, 8'd219},  {8'd102, 8'd177, 8'd222},
        {8'd111, 8'd182, 8'd225}, {8'd120, 8'd187, 8'd227}, {8'd129, 8'd193, 8'd230},
        {8'd139, 8'd198, 8'd233}, {8'd148, 8'd203, 8'd236}, {8'd157, 8'd208, 8'd238},
        {8'd166, 8'd213, 8'd241}, {8'd175, 8'd218, 8'd244}, {8'd185, 8'd224, 8'd247},
        {8'd175, 8'd215, 8'd247}, {8'd166, 8'd207, 8'd247}, {8'd157, 8'd198, 8'd247},
        {8'd148, 8'd190, 8'd247}, {8'd138, 8'd182, 8'd247}, {8'd129, 8'd173, 8'd247},
        {8'd120, 8'd165, 8'd248}, {8'd111, 8'd157, 8'd248}, {8'd101, 8'd148, 8'd248},
        {8'd92, 8'd140, 8'd248},  {8'd83, 8'd132, 8'd248},  {8'd74, 8'd123, 8'd248},
        {8'd64, 8'd115, 8'd248},  {8'd55, 8'd107, 8'd249},  {8'd46, 8'd98, 8'd249},
        {8'd37, 8'd90, 8'd249},   {8'd27, 8'd82, 8'd249},   {8'd18, 8'd73, 8'd249},
        {8'd9, 8'd65, 8'd249},    {8'd0, 8'd57, 8'd250},    {8'd0, 8'd57, 8'd242},
        {8'd0, 8'd57, 8'd234},    {8'd0, 8'd58, 8'd226},    {8'd0, 8'd58, 8'd218},
        {8'd0, 8'd59, 8'd211},    {8'd0, 8'd59, 8'd203},    {8'd0, 8'd59, 8'd195},
        {8'd0, 8'd60, 8'd187},    {8'd0, 8'd60, 8'd179},    {8'd0, 8'd61, 8'd172},
        {8'd0, 8'd61, 8'd164},    {8'd0, 8'd61, 8'd156},    {8'd0, 8'd62, 8'd148},
        {8'd0, 8'd62, 8'd140},    {8'd0, 8'd63, 8'd133},    {8'd0, 8'd63, 8'd125},
        {8'd0, 8'd63, 8'd117},    {8'd0, 8'd64, 8'd109},    {8'd0, 8'd64, 8'd101},
        {8'd0, 8'd65, 8'd94},     {8'd0, 8'd67, 8'd98},     {8'd0, 8'd70, 8'd103},
        {8'd0, 8'd73, 8'd108},    {8'd0, 8'd76, 8'd113},    {8'd0, 8'd79, 8'd118},
        {8'd0, 8'd81, 8'd123},    {8'd0, 8'd84, 8'd128},    {8'd0, 8'd87, 8'd133},
        {8'd0, 8'd90, 8'd138},    {8'd0, 8'd93, 8'd143},    {8'd0, 8'd95, 8'd147},
        {8'd0, 8'd98, 8'd152},    {8'd0, 8'd101, 8'd157},   {8'd0, 8'd104, 8'd162},
        {8'd0, 8'd107, 8'd167},   {8'd0, 8'd109, 8'd172},   {8'd0, 8'd112, 8'd177},
        {8'd0, 8'd115, 8'd182},   {8'd0, 8'd118, 8'd187}
    };

    localparam logic [23:0] STRIPE_COLORS [24] = '{
        {8'd1, 8'd121, 8'd192},   {8'd31, 8'd138, 8'd201},  {8'd62, 8'd155, 8'd210},
        {8'd93, 8'd172, 8'd219},  {8'd123, 8'd189, 8'd228}, {8'd152, 8'd206, 8'd237},
        {8'd185, 8'd224, 8'd247}, {8'd152, 8'd196, 8'd247}, {8'd123, 8'd168, 8'd248},
        {8'd92, 8'd140, 8'd248},  {8'd61, 8'd112, 8'd249},  {8'd30, 8'd84, 8'd249},
        {8'd0, 8'd57, 8'd250},    {8'd0, 8'd58, 8'd224},    {8'd0, 8'd59, 8'd198},
        {8'd0, 8'd61, 8'd172},    {8'd0, 8'd62, 8'd146},    {8'd0, 8'd62, 8'd120},
        {8'd0, 8'd65, 8'd94},     {8'd0, 8'd74, 8'd110},    {8'd0, 8'd83, 8'd126},
        {8'd0, 8'd93, 8'd143},    {8'd0, 8'd102, 8'd159},   {8'd0, 8'd111, 8'd175}
    };

    logic [23:0]      expected_colors [$];
    logic [COL_W-1:0] ring_col = CENTER_COL_RST;
    logic [ROW_W-1:0] ring_row = CENTER_ROW_RST;
    int               fails = 0;
    int               matched = 0;
    int               queue_depth = 0;

    assign fail_count = fails;
    assign pending    = queue_depth;
    assign checked    = matched;

    function automatic logic [23:0] cell_color(
        input logic [1:0]  m,
        input logic [4:0]  c,
        input logic [3:0]  r,
        input logic [31:0] t,
        input logic [4:0]  cc,
        input logic [3:0]  cr
    );
        int unsigned ci, ri, ti, cci, cri, s, p, w, d, k;
        logic [7:0]  rd, gr, bl;
        ci  = c;
        ri  = r;
        ti  = t;
        cci = cc;
        cri = cr;
        rd  = 8'd0;
        gr  = 8'd0;
        bl  = 8'd0;
        p   = (ri * GRID_COLS + ci + ((ti / 2) % 2550) / 10) % 255;
        case (mode_t'(m))
            MODE_GRADIENT:
            begin
                if (p > 127)
                begin
                    p = 255 - p;
                end
                gr = 8'(2 * p);
                bl = 8'(255 - 2 * p);
            end
            MODE_RINGS:
            begin
                s = (ti % 9600) / 120;
                d = ((ci >= cci) ? ci - cci : cci - ci) + ((ri >= cri) ? ri - cri : cri - ri);
                k = (d + 80 - s) % 80;
                {rd, gr, bl} = RING_COLORS[k];
            end
            MODE_STRIPES:
            begin
                s = (ti % 12000) / 100;
                k = (GRID_ROWS % 24 + 24 - ri % 24 + s) % 24;
                {rd, gr, bl} = STRIPE_COLORS[k];
            end
            default:
            begin
                w = 255 - p;
                if (w < 85)
                begin
                    rd = 8'(255 - 3 * w);
                    bl = 8'(3 * w);
                end
                else if (w < 170)
                begin
                    w  = w - 85;
                    gr = 8'(3 * w);
                    bl = 8'(255 - 3 * w);
                end
                else
                begin
                    w  = w - 170;
                    rd = 8'(3 * w);
                    gr = 8'(255 - 3 * w);
                end
            end
        endcase
        return {rd, gr, bl};
    endfunction

    task automatic compare_channel(input string chan, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, chan, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [23:0] want;
        if (!rst_n)
        begin
            ring_col = CENTER_COL_RST;
            ring_row = CENTER_ROW_RST;
            expected_colors.delete();
            queue_depth = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CENTER_COL)
                begin
                    ring_col = cfg_data[COL_W-1:0];
                end
                else if (cfg_index == CFG_CENTER_ROW)
                begin
                    ring_row = cfg_data[ROW_W-1:0];
                end
            end
            if (color_valid && !color_stall)
            begin
                if (expected_colors.size() == 0)
                begin
                    fails++;
                    $display("%0t: color transaction with none expected, actual %0d %0d %0d",
                             $time, red, green, blue);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    compare_channel("red", want[23:16], red);
                    compare_channel("green", want[15:8], green);
                    compare_channel("blue", want[7:0], blue);
                    matched++;
                end
            end
            if (cell_valid && !cell_stall)
            begin
                expected_colors = {expected_colors,
                                   cell_color(mode, cell_col, cell_row, time_ms,
                                              ring_col, ring_row)};
            end
            queue_depth = expected_colors.size();
        end
    end

endmodule

/* tb/led_grid_pattern_generator_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the LED grid pattern generator: stimulus, receiver stalls and verdict.
module led_grid_pattern_generator_tb;
    import lgpg_pkg::*;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cell_valid  = 1'b0;
    logic                  cell_stall;
    logic [1:0]            mode        = '0;
    logic [COL_W-1:0]      cell_col    = '0;
    logic [ROW_W-1:0]      cell_row    = '0;
    logic [TIME_W-1:0]     time_ms     = '0;
    logic                  color_valid;
    logic                  color_stall = 1'b0;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int fail_count;
    int pending;
    int checked;
    int cells_sent  = 0;
    int reg_writes  = 0;
    int settings    = 1;
    int stall_style = 0;
    int stall_phase = 0;
    int stall_run   = 0;
    logic stall_level = 1'b0;

    always #1 clk = ~clk;

    led_grid_pattern_generator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .mode        (mode),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .time_ms     (time_ms),
        .color_valid (color_valid),
        .color_stall (color_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    led_grid_pattern_generator_checker color_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .mode        (mode),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .time_ms     (time_ms),
        .color_valid (color_valid),
        .color_stall (color_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            color_stall <= 1'b0;
        end
        else
        begin
            case (stall_style)
                0: color_stall <= 1'b0;
                1: color_stall <= ($urandom_range(0, 3) == 0);
                2: color_stall <= ($urandom_range(0, 9) < 7);
                3:
                begin
                    stall_phase = stall_phase + 1;
                    color_stall <= ((stall_phase % 11) < 4);
                end
                default:
                begin
                    if (stall_run == 0)
                    begin
                        stall_run   = $urandom_range(1, 20);
                        stall_level = ~stall_level;
                    end
                    stall_run = stall_run - 1;
                    color_stall <= stall_level;
                end
            endcase
        end
    end

    task automatic push_cell(input logic [1:0] m, input logic [4:0] c, input logic [3:0] r,
                             input logic [31:0] t);
        @(negedge clk);
        cell_valid <= 1'b1;
        mode       <= m;
        cell_col   <= c;
        cell_row   <= r;
        time_ms    <= t;
        do @(posedge clk); while (cell_stall);
        cells_sent++;
    endtask

    task automatic idle_cells(input int n);
        repeat (n)
        begin
            @(negedge clk);
            cell_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        idle_cells(1);
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic rand_cell();
        logic [1:0]  m;
        logic [4:0]  c;
        logic [3:0]  r;
        logic [31:0] t;
        int          pick;
        int unsigned step;
        m = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 85)
        begin
            c = 5'($urandom_range(0, 16));
            r = 4'($urandom_range(0, 8));
        end
        else
        begin
            c = 5'($urandom);
            r = 4'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            t = $urandom;
        end
        else if (pick < 7)
        begin
            t = $urandom_range(0, 24000);
        end
        else
        begin
            // near the edges where a time step changes
            case ($urandom_range(0, 2))
                0: step = 20;
                1: step = 100;
                default: step = 120;
            endcase
            t = step * $urandom_range(0, 1000) + $urandom_range(0, 2) - 1;
        end
        push_cell(m, c, r, t);
    endtask

    task automatic run_phase(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            if (burst > left)
            begin
                burst = left;
            end
            repeat (burst) rand_cell();
            left -= burst;
            if ($urandom_range(0, 14) == 0)
            begin
                drain();
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                idle_cells($urandom_range(1, 6));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                stall_style = $urandom_range(0, 4);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [4:0] col_set [7];
        logic [4:0] row_set [7];
        col_set = '{5'd8, 5'd0, 5'd31, 5'd16, 5'd31, 5'd0, 5'd0};
        // row value 5'h1F checks that the top bit is dropped
        row_set = '{5'd4, 5'd0, 5'h1F, 5'd8, 5'd0, 5'd15, 5'd0};
        col_set[6] = 5'($urandom);
        row_set[6] = 5'($urandom);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        stall_style = 1;
        push_cell(MODE_GRADIENT, 5'd0, 4'd0, 32'd0);
        push_cell(MODE_GRADIENT, 5'd8, 4'd7, 32'd0);
        push_cell(MODE_GRADIENT, 5'd9, 4'd7, 32'd0);
        push_cell(MODE_GRADIENT, 5'd16, 4'd8, 32'hFFFF_FFFF);
        push_cell(MODE_GRADIENT, 5'd31, 4'd15, 32'd5099);
        push_cell(MODE_RINGS, 5'd8, 4'd4, 32'd0);
        push_cell(MODE_RINGS, 5'd0, 4'd0, 32'd9599);
        push_cell(MODE_RINGS, 5'd16, 4'd8, 32'd9600);
        push_cell(MODE_RINGS, 5'd31, 4'd15, 32'd119);
        push_cell(MODE_RINGS, 5'd31, 4'd15, 32'hFFFF_FFFF);
        push_cell(MODE_STRIPES, 5'd0, 4'd0, 32'd0);
        push_cell(MODE_STRIPES, 5'd16, 4'd8, 32'd11999);
        push_cell(MODE_STRIPES, 5'd3, 4'd9, 32'd12000);
        push_cell(MODE_STRIPES, 5'd31, 4'd15, 32'hFFFF_FFFF);
        push_cell(MODE_STRIPES, 5'd5, 4'd10, 32'd99);
        push_cell(MODE_RAINBOW, 5'd0, 4'd0, 32'd0);
        push_cell(MODE_RAINBOW, 5'd0, 4'd5, 32'd0);
        push_cell(MODE_RAINBOW, 5'd1, 4'd5, 32'd0);
        push_cell(MODE_RAINBOW, 5'd0, 4'd10, 32'd0);
        push_cell(MODE_RAINBOW, 5'd1, 4'd10, 32'd0);
        push_cell(MODE_RAINBOW, 5'd16, 4'd8, 32'hFFFF_FFFF);
        push_cell(MODE_RAINBOW, 5'd31, 4'd15, 32'd5100);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(CFG_CENTER_COL, col_set[ph]);
                write_reg(CFG_CENTER_ROW, row_set[ph]);
                settings++;
            end
            stall_style = ph % 5;
            run_phase(265);
            drain();
        end

        repeat (20) @(negedge clk);
        $display("covered %0d cells over all four patterns, %0d ring centers, %0d register writes",
                 cells_sent, settings, reg_writes);
        $display("%0d colors checked, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
        begin
            $display("led_grid_pattern_generator_tb passed");
        end
        else
        begin
            $display("led_grid_pattern_generator_tb failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("led_grid_pattern_generator_tb failed");
        $finish;
    end

endmodule
